@@ src/ccbt_pkg.sv @@
// Shared types, constants and operation codes of the channel binding table.
package ccbt_pkg;

  localparam int BindingsDefault = 8;
  localparam int FiltersDefault  = 8;

  typedef enum logic [3:0] {
    KIND_OPEN    = 4'd0,
    KIND_CLOSE   = 4'd1,
    KIND_SETCNT  = 4'd2,
    KIND_WRFILT  = 4'd3,
    KIND_ACCEPT  = 4'd4,
    KIND_QUERY   = 4'd5,
    KIND_LOOKUP  = 4'd6,
    KIND_DETACH  = 4'd7,
    KIND_REMOVE  = 4'd8
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC,
    ST_APPLY,
    ST_FREAD,
    ST_FCMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  channel;
    logic [31:0] ifc_id;
    logic [31:0] frame_id;
    logic [31:0] filter_value;
    logic [31:0] filter_mask;
    logic [2:0]  filter_slot;
    logic [7:0]  filter_total;
    logic        echo_off;
    logic        write_allowed;
    logic        want_reliable;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  channel_out;
    logic [31:0] interface_out;
    logic        interface_valid;
    logic        can_write_out;
    logic        reliable_out;
    logic        echo_off_out;
  } rsp_t;

endpackage

@@ src/ccbt_filter_mem.sv @@
// Filter store memory with one write port and one registered read port.
module ccbt_filter_mem #(
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [63:0]              wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [63:0]              rdata
);
  logic [63:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/can_channel_binding_table.sv @@
// Top level of the channel binding table with its sequencer and slot registers.
// One item is accepted when start is high and busy is low; busy stays high until
// done pulses with the result for one cycle, and the receiver cannot stall, so the
// result must be taken in that cycle. An item scans the binding slots one per
// cycle through compare logic shared by all slots, then passes an apply state; open
// replaces the apply state with a channel search, and an accept check then reads
// and compares the filters one at a time in a read and a compare state because of
// the registered filter memory read.
module can_channel_binding_table #(
  parameter int BINDINGS = ccbt_pkg::BindingsDefault,
  parameter int FILTERS  = ccbt_pkg::FiltersDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ccbt_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done,
  output ccbt_pkg::rsp_t rsp
);
  import ccbt_pkg::*;

  localparam int SW = (BINDINGS > 1) ? $clog2(BINDINGS) : 1;
  localparam int FW = (FILTERS > 1) ? $clog2(FILTERS) : 1;
  localparam int AW = $clog2(BINDINGS * FILTERS) > 0 ? $clog2(BINDINGS * FILTERS) : 1;
  localparam int CW = $clog2(FILTERS + 1);
  localparam int AC = $clog2(BINDINGS + 2);

  state_t state, state_next;
  cmd_t   c;
  rsp_t   r;

  logic [BINDINGS-1:0] slot_used, slot_dormant;
  logic [2:0]  slot_flags [BINDINGS];
  logic [31:0] slot_interface [BINDINGS];
  logic [7:0]  slot_channel [BINDINGS];
  logic [CW-1:0] slot_filter_count [BINDINGS];
  logic [7:0]  chan_cursor;

  logic [SW:0]   idx;
  logic          found;
  logic [SW-1:0] hit;
  logic          free_found;
  logic [SW-1:0] free_slot;
  logic [AC-1:0] tries;
  logic [CW-1:0] fidx;
  logic          scan_last;
  logic [SW-1:0] i;

  logic          m_used, m_dorm, ch_match, if_match, cand_match;
  logic [63:0]   rdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;

  assign i         = idx[SW-1:0];
  assign scan_last = (idx == (SW+1)'(BINDINGS - 1));
  assign m_used    = slot_used[i];
  assign m_dorm    = slot_dormant[i];
  assign ch_match  = m_used && (slot_channel[i] == c.channel);
  assign if_match  = m_used && (slot_interface[i] == c.ifc_id);
  assign cand_match = m_used && (slot_channel[i] == chan_cursor);

  assign waddr = AW'(hit * FILTERS + c.filter_slot[FW-1:0]);
  assign raddr = AW'(hit * FILTERS + fidx[FW-1:0]);
  assign we    = (state == ST_APPLY) && (kind_t'(c.kind) == KIND_WRFILT) && found
                 && (32'(c.filter_slot) < FILTERS);

  ccbt_filter_mem #(.Depth(BINDINGS * FILTERS)) u_mem (
    .clk(clk), .we(we), .waddr(waddr),
    .wdata({c.filter_mask, c.filter_value}), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_SCAN;
      ST_SCAN:  if (scan_last) state_next = (kind_t'(c.kind) == KIND_OPEN) ? ST_ALLOC
                                                                          : ST_APPLY;
      ST_ALLOC: begin
        if (!free_found || tries == AC'(BINDINGS + 1)) state_next = ST_DONE;
        else if (scan_last && !cand_match) state_next = ST_DONE;
      end
      ST_APPLY: state_next = (kind_t'(c.kind) == KIND_ACCEPT && found &&
                              slot_filter_count[hit] != '0) ? ST_FREAD : ST_DONE;
      ST_FREAD: state_next = ST_FCMP;
      ST_FCMP:  state_next = (((rdata[31:0] & rdata[63:32]) ==
                               (c.frame_id & rdata[63:32])) ||
                              fidx + CW'(1) >= slot_filter_count[hit]) ? ST_DONE
                                                                        : ST_FREAD;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
    done = (state == ST_DONE);
    rsp  = done ? r : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot_used <= '0;
      slot_dormant <= '0;
      chan_cursor <= '0;
      for (int k = 0; k < BINDINGS; k++) begin
        slot_flags[k] <= '0;
        slot_interface[k] <= '0;
        slot_channel[k] <= '0;
        slot_filter_count[k] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          c <= cmd;
          r <= '0;
          idx <= '0;
          found <= 1'b0;
          hit <= '0;
          free_found <= 1'b0;
          free_slot <= '0;
          tries <= '0;
          fidx <= '0;
        end
        ST_SCAN: begin
          idx <= scan_last ? '0 : idx + 1'b1;
          if (!m_used && !free_found) begin
            free_found <= 1'b1;
            free_slot <= i;
          end
          unique case (kind_t'(c.kind)) inside
            KIND_CLOSE, KIND_SETCNT, KIND_WRFILT, KIND_ACCEPT, KIND_QUERY: begin
              if (ch_match && !found) begin
                found <= 1'b1;
                hit <= i;
                if (kind_t'(c.kind) == KIND_QUERY) begin
                  r.ok <= 1'b1;
                  r.echo_off_out <= slot_flags[i][0];
                  r.can_write_out <= slot_flags[i][1];
                  r.reliable_out <= slot_flags[i][2];
                end
              end
              if (kind_t'(c.kind) == KIND_QUERY && ch_match && !m_dorm &&
                  !r.interface_valid) begin
                r.interface_valid <= 1'b1;
                r.interface_out <= slot_interface[i];
              end
            end
            KIND_LOOKUP: if (if_match && !m_dorm && !r.ok) begin
              r.ok <= 1'b1;
              r.channel_out <= slot_channel[i];
            end
            KIND_DETACH: if (if_match && !m_dorm) begin
              slot_dormant[i] <= 1'b1;
              r.ok <= 1'b1;
            end
            KIND_REMOVE: if (if_match) begin
              slot_used[i] <= 1'b0;
              slot_dormant[i] <= 1'b0;
              slot_flags[i] <= '0;
              slot_interface[i] <= '0;
              slot_channel[i] <= '0;
              slot_filter_count[i] <= '0;
              r.ok <= 1'b1;
            end
            default: ;
          endcase
        end
        ST_ALLOC: begin
          if (free_found && tries != AC'(BINDINGS + 1)) begin
            if (cand_match) begin
              chan_cursor <= chan_cursor + 8'd1;
              tries <= tries + 1'b1;
              idx <= '0;
            end else if (scan_last) begin
              chan_cursor <= chan_cursor + 8'd1;
              slot_used[free_slot] <= 1'b1;
              slot_dormant[free_slot] <= 1'b0;
              slot_flags[free_slot] <= {c.want_reliable, c.write_allowed, c.echo_off};
              slot_interface[free_slot] <= c.ifc_id;
              slot_channel[free_slot] <= chan_cursor;
              slot_filter_count[free_slot] <= '0;
              r.ok <= 1'b1;
              r.channel_out <= chan_cursor;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_APPLY: begin
          unique case (kind_t'(c.kind))
            KIND_CLOSE: if (found) begin
              slot_used[hit] <= 1'b0;
              slot_dormant[hit] <= 1'b0;
              slot_flags[hit] <= '0;
              slot_interface[hit] <= '0;
              slot_channel[hit] <= '0;
              slot_filter_count[hit] <= '0;
              r.ok <= 1'b1;
            end
            KIND_SETCNT: if (found && 32'(c.filter_total) <= FILTERS) begin
              slot_filter_count[hit] <= CW'(c.filter_total);
              r.ok <= 1'b1;
            end
            KIND_WRFILT: if (we) r.ok <= 1'b1;
            KIND_ACCEPT: if (!found || slot_filter_count[hit] == '0) r.ok <= 1'b1;
            default: ;
          endcase
        end
        ST_FREAD: ;
        ST_FCMP: begin
          if ((rdata[31:0] & rdata[63:32]) == (c.frame_id & rdata[63:32])) r.ok <= 1'b1;
          fidx <= fidx + CW'(1);
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");
  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item not taken");
  a_done_ends: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after done");
endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the channel binding table with a built-in predictor.
`timescale 1ns / 100ps

module testbench;
  import ccbt_pkg::*;

  localparam int NB = BindingsDefault;
  localparam int NF = FiltersDefault;

  logic clk;
  logic rst;
  logic start;
  cmd_t cmd;
  logic busy;
  logic done;
  rsp_t rsp;

  can_channel_binding_table dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .rsp(rsp)
  );

  logic        tbl_used [NB];
  logic        tbl_dorm [NB];
  logic [2:0]  tbl_flags [NB];
  logic [31:0] tbl_ifc [NB];
  logic [7:0]  tbl_chan [NB];
  logic [3:0]  tbl_cnt [NB];
  logic [31:0] flt_val [NB*NF];
  logic [31:0] flt_mask [NB*NF];
  logic        flt_written [NB*NF];
  logic [7:0]  chan_next;

  cmd_t pending_items[$];
  rsp_t expected_rsps[$];
  int   gap;
  int   errors;
  bit   hold_off;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic int slot_for(logic [7:0] ch);
    for (int i = 0; i < NB; i++) begin
      if (tbl_used[i] && tbl_chan[i] == ch) return i;
    end
    return -1;
  endfunction

  function automatic void clear_binding(int i);
    tbl_used[i] = 0;
    tbl_dorm[i] = 0;
    tbl_flags[i] = 0;
    tbl_ifc[i] = 0;
    tbl_chan[i] = 0;
    tbl_cnt[i] = 0;
  endfunction

  function automatic rsp_t predict_binding_op(cmd_t c);
    rsp_t r;
    int s;
    logic [7:0] ch;
    r = '0;
    case (c.kind)
      KIND_OPEN: begin
        s = -1;
        for (int i = 0; i < NB; i++) begin
          if (!tbl_used[i] && s < 0) s = i;
        end
        if (s >= 0) begin
          for (int a = 0; a < NB + 1; a++) begin
            ch = chan_next;
            chan_next = chan_next + 8'd1;
            if (slot_for(ch) < 0) begin
              tbl_used[s] = 1;
              tbl_dorm[s] = 0;
              tbl_flags[s] = {c.want_reliable, c.write_allowed, c.echo_off};
              tbl_ifc[s] = c.ifc_id;
              tbl_chan[s] = ch;
              tbl_cnt[s] = 0;
              r.ok = 1;
              r.channel_out = ch;
              break;
            end
          end
        end
      end
      KIND_CLOSE: begin
        s = slot_for(c.channel);
        if (s >= 0) begin
          clear_binding(s);
          r.ok = 1;
        end
      end
      KIND_SETCNT: begin
        s = slot_for(c.channel);
        if (s >= 0 && c.filter_total <= NF) begin
          tbl_cnt[s] = c.filter_total[3:0];
          r.ok = 1;
        end
      end
      KIND_WRFILT: begin
        s = slot_for(c.channel);
        if (s >= 0 && c.filter_slot < NF) begin
          flt_val[s*NF + c.filter_slot] = c.filter_value;
          flt_mask[s*NF + c.filter_slot] = c.filter_mask;
          flt_written[s*NF + c.filter_slot] = 1;
          r.ok = 1;
        end
      end
      KIND_ACCEPT: begin
        s = slot_for(c.channel);
        if (s < 0 || tbl_cnt[s] == 0) begin
          r.ok = 1;
        end else begin
          for (int f = 0; f < tbl_cnt[s]; f++) begin
            if ((c.frame_id & flt_mask[s*NF+f]) == (flt_val[s*NF+f] & flt_mask[s*NF+f]))
              r.ok = 1;
          end
        end
      end
      KIND_QUERY: begin
        s = slot_for(c.channel);
        if (s >= 0) begin
          r.ok = 1;
          r.echo_off_out = tbl_flags[s][0];
          r.can_write_out = tbl_flags[s][1];
          r.reliable_out = tbl_flags[s][2];
        end
        for (int i = 0; i < NB; i++) begin
          if (tbl_used[i] && !tbl_dorm[i] && tbl_chan[i] == c.channel &&
              !r.interface_valid) begin
            r.interface_out = tbl_ifc[i];
            r.interface_valid = 1;
          end
        end
      end
      KIND_LOOKUP: begin
        for (int i = 0; i < NB; i++) begin
          if (tbl_used[i] && !tbl_dorm[i] && tbl_ifc[i] == c.ifc_id && !r.ok) begin
            r.ok = 1;
            r.channel_out = tbl_chan[i];
          end
        end
      end
      KIND_DETACH: begin
        for (int i = 0; i < NB; i++) begin
          if (tbl_used[i] && !tbl_dorm[i] && tbl_ifc[i] == c.ifc_id) begin
            tbl_dorm[i] = 1;
            r.ok = 1;
          end
        end
      end
      KIND_REMOVE: begin
        for (int i = 0; i < NB; i++) begin
          if (tbl_used[i] && tbl_ifc[i] == c.ifc_id) begin
            clear_binding(i);
            r.ok = 1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // An accept check must not read filter entries that were never written.
  function automatic bit reads_unwritten(cmd_t c);
    int s;
    if (c.kind != KIND_ACCEPT) return 0;
    s = slot_for(c.channel);
    if (s < 0) return 0;
    for (int f = 0; f < tbl_cnt[s]; f++) begin
      if (!flt_written[s*NF+f]) return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
      gap <= 0;
    end else if (start && !busy) begin
      start <= 0;
      gap <= $urandom_range(0, 3);
    end else if (!start) begin
      if (gap > 0) begin
        gap <= gap - 1;
      end else if (pending_items.size() > 0 && !(hold_off && expected_rsps.size() > 0)) begin
        cmd_t c;
        c = pending_items.pop_front();
        if (reads_unwritten(c)) c.kind = KIND_QUERY;
        expected_rsps.push_back(predict_binding_op(c));
        cmd <= c;
        start <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result %p", $time, rsp);
        errors++;
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (rsp !== e) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, rsp);
          errors++;
        end
      end
    end
  end

  function automatic cmd_t rand_item(bit well_formed);
    cmd_t c;
    c = '0;
    c.kind = well_formed ? kind_t'($urandom_range(0, 8)) : 4'($urandom);
    c.channel = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 20)) : 8'($urandom);
    c.ifc_id = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 5) : $urandom;
    c.frame_id = $urandom;
    c.filter_value = $urandom;
    c.filter_mask = ($urandom_range(0, 1) != 0) ? $urandom & $urandom & $urandom : $urandom;
    c.filter_slot = 3'($urandom);
    c.filter_total = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 9)) : 8'($urandom);
    c.echo_off = 1'($urandom);
    c.write_allowed = 1'($urandom);
    c.want_reliable = 1'($urandom);
    return c;
  endfunction

  task automatic add_item(logic [3:0] k, logic [7:0] ch, logic [31:0] ifc,
                          logic [31:0] fid, logic [31:0] fv, logic [31:0] fm,
                          logic [2:0] fs, logic [7:0] ft, logic [2:0] fl);
    cmd_t c;
    c = '{k, ch, ifc, fid, fv, fm, fs, ft, fl[0], fl[1], fl[2]};
    pending_items.push_back(c);
  endtask

  initial begin
    errors = 0;
    hold_off = 0;
    rst = 1;
    start = 0;
    cmd = '0;
    for (int i = 0; i < NB; i++) clear_binding(i);
    for (int i = 0; i < NB*NF; i++) begin
      flt_val[i] = 0;
      flt_mask[i] = 0;
      flt_written[i] = 0;
    end
    chan_next = 0;
    repeat (10) @(posedge clk);
    rst <= 0;

    add_item(KIND_ACCEPT, 8'd0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    add_item(KIND_QUERY, 8'd255, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 9; i++)
      add_item(KIND_OPEN, 0, (i == 0) ? 32'hFFFF_FFFF : i, 0, 0, 0, 0, 0, 3'(i));
    add_item(KIND_WRFILT, 8'd0, 0, 0, 32'h0000_0123, 32'hFFFF_FFFF, 3'd0, 0, 0);
    add_item(KIND_WRFILT, 8'd0, 0, 0, 32'hFFFF_FFFF, 32'h0000_FF00, 3'd7, 0, 0);
    add_item(KIND_SETCNT, 8'd0, 0, 0, 0, 0, 0, 8'd9, 0);
    add_item(KIND_SETCNT, 8'd0, 0, 0, 0, 0, 0, 8'd1, 0);
    add_item(KIND_ACCEPT, 8'd0, 0, 32'h0000_0123, 0, 0, 0, 0, 0);
    add_item(KIND_ACCEPT, 8'd0, 0, 32'h0000_0124, 0, 0, 0, 0, 0);
    add_item(KIND_SETCNT, 8'd0, 0, 0, 0, 0, 0, 8'd0, 0);
    add_item(KIND_ACCEPT, 8'd0, 0, 32'h0000_0124, 0, 0, 0, 0, 0);
    add_item(KIND_DETACH, 0, 32'd1, 0, 0, 0, 0, 0, 0);
    add_item(KIND_QUERY, 8'd1, 0, 0, 0, 0, 0, 0, 0);
    add_item(KIND_LOOKUP, 0, 32'd1, 0, 0, 0, 0, 0, 0);
    add_item(KIND_REMOVE, 0, 32'd1, 0, 0, 0, 0, 0, 0);
    add_item(KIND_CLOSE, 8'd0, 0, 0, 0, 0, 0, 0, 0);
    add_item(4'd15, 8'd255, 32'hFFFF_FFFF, 0, 0, 0, 3'd7, 8'd255, 3'd7);

    while (pending_items.size() > 0 || start) @(posedge clk);
    for (int i = 0; i < 400; i++) begin
      bit wf;
      wf = $urandom_range(0, 19) != 0;
      pending_items.push_back(rand_item(wf));
    end
    while (pending_items.size() > 0) @(posedge clk);
    // One pause mid-run lets every outstanding result drain first.
    hold_off = 1;
    for (int i = 0; i < 700; i++) begin
      bit wf;
      wf = $urandom_range(0, 19) != 0;
      pending_items.push_back(rand_item(wf));
    end
    while (expected_rsps.size() > 0) @(posedge clk);
    hold_off = 0;

    while (pending_items.size() > 0 || start || expected_rsps.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
